// File: rtl/odq_pkg.sv
// ----------------------------------------------------------------------------
// odq_pkg: shared types and constants of the ordered deque
// Capacity, field layouts of the stream words, command, status and sequencer
// codes, and the ring-buffer address helper.
// ----------------------------------------------------------------------------
`default_nettype none

package odq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned HandleW  = 32;
  localparam int unsigned CountW   = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_REMOVE     = 3'd2,
    CMD_MOVE_FRONT = 3'd3,
    CMD_DROP_FRONT = 3'd4,
    CMD_DROP_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_FAIL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_ENDS,
    S_REPORT
  } state_e;

  // Input word, command in the lowest bits.
  typedef struct packed {
    logic [InDataW-HandleW-4:0] pad;
    logic [HandleW-1:0]         item_handle;
    logic [2:0]                 command;
  } in_word_t;

  // Result word, status in the lowest bits.
  typedef struct packed {
    logic [CountW-1:0]  entry_count;
    logic               is_empty;
    logic [HandleW-1:0] back_item;
    logic [HandleW-1:0] front_item;
    status_e            status;
  } out_word_t;

  // Physical ring address of a logical position counted from the head.
  function automatic logic [IdxW-1:0] phys_addr(input logic [IdxW-1:0] head,
                                                input logic [CntW-1:0] idx);
    logic [IdxW:0] sum;
    sum = {1'b0, head} + (IdxW + 1)'(idx);
    if (sum >= (IdxW + 1)'(Capacity)) begin
      sum = sum - (IdxW + 1)'(Capacity);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/ordered_deque_with_remove.sv
// ----------------------------------------------------------------------------
// ordered_deque_with_remove: bounded ordered list of nonzero handles
// Push front or back, remove the first match, move a match to the front,
// drop the front or back entry; every command reports status and list ends.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Width  Contents (lowest bit first)
//  s_axis    in         40     command[2:0], item_handle[31:0], zero pad
//  m_axis    out        72     status[1:0], front_item[31:0], back_item[31:0],
//                              is_empty, entry_count[4:0]
//
// One command is worked on at a time; s_axis_tready is high only while the
// sequencer is idle. Pushes, drops and rejected commands pass through the
// dispatch, ends and report states to the result register. Remove and
// move-to-front search the list from the front, one entry per cycle through
// the shared RAM read port, then shift the entries ahead of the match back by
// one, one per cycle. A stalled result holds in the output register and the
// sequencer waits with the next result behind it.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_deque_with_remove (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command[2:0], item_handle[34:3], zero pad[39:35]
  input  wire logic [odq_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // status[1:0], front_item[33:2], back_item[65:34], is_empty[66],
  // entry_count[71:67]
  output logic      [odq_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready
);

  import odq_pkg::*;

  // The list lives in a ring buffer: head_q is the physical address of the
  // front entry and count_q the number of entries held.
  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [HandleW-1:0] handle_q, handle_d;
  status_e            status_q, status_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  // Walking index: next position to read while searching, and the position
  // whose predecessor is read next while shifting.
  logic [CntW-1:0]    idx_q, idx_d;
  // Position whose read data arrives in this cycle, and whether it is live.
  logic [CntW-1:0]    pidx_q, pidx_d;
  logic               pend_q, pend_d;
  out_word_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [HandleW-1:0] ram_wdata;
  logic               ra_en, rb_en;
  logic [IdxW-1:0]    ra_addr, rb_addr;
  logic [HandleW-1:0] ra_data, rb_data;

  in_word_t           in_word;
  logic               in_accept;
  logic               handle_zero;
  logic               list_empty;
  logic               search_hit;
  logic               search_more;
  logic               shift_done;
  logic               out_free;
  logic [IdxW-1:0]    head_prev;
  logic [CntW-1:0]    last_pos;

  assign in_word       = in_word_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign handle_zero = (handle_q == '0);
  assign list_empty  = (count_q == '0);
  assign search_hit  = pend_q && (ra_data == handle_q);
  assign search_more = (idx_q < count_q);
  assign shift_done  = !pend_q && (idx_q == '0);
  assign out_free    = !out_valid_q || m_axis_tready;
  assign head_prev   = (head_q == '0) ? IdxW'(Capacity - 1) : head_q - 1'b1;
  assign last_pos    = list_empty ? '0 : count_q - 1'b1;

  odq_ram #(
    .Width (HandleW),
    .Depth (Capacity)
  ) u_odq_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .ra_en_i   (ra_en),
    .ra_addr_i (ra_addr),
    .ra_data_o (ra_data),
    .rb_en_i   (rb_en),
    .rb_addr_i (rb_addr),
    .rb_data_o (rb_data)
  );

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if ((cmd_q == CMD_REMOVE || cmd_q == CMD_MOVE_FRONT) && !handle_zero) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_ENDS;
        end
      end
      S_SEARCH: begin
        if (search_hit) begin
          state_d = S_SHIFT;
        end else if (!search_more) begin
          state_d = S_ENDS;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = S_ENDS;
        end
      end
      S_ENDS: begin
        state_d = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer: datapath control and register updates.
  always_comb begin
    cmd_d       = cmd_q;
    handle_d    = handle_q;
    status_d    = status_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = handle_q;
    ra_en       = 1'b0;
    ra_addr     = head_q;
    rb_en       = 1'b0;
    rb_addr     = head_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d    = cmd_e'(in_word.command);
          handle_d = in_word.item_handle;
          status_d = ST_OK;
        end
      end
      S_DISPATCH: begin
        idx_d  = '0;
        pend_d = 1'b0;
        unique case (cmd_q) inside
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (handle_zero) begin
              status_d = ST_INVALID;
            end else if (count_q == CntW'(Capacity)) begin
              status_d = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + 1'b1;
              if (cmd_q == CMD_PUSH_FRONT) begin
                head_d    = head_prev;
                ram_waddr = head_prev;
              end else begin
                ram_waddr = phys_addr(head_q, count_q);
              end
            end
          end
          CMD_REMOVE: begin
            if (handle_zero) begin
              status_d = ST_INVALID;
            end
          end
          CMD_MOVE_FRONT: begin
            if (handle_zero) begin
              status_d = ST_FAIL;
            end
          end
          CMD_DROP_FRONT: begin
            if (!list_empty) begin
              head_d  = phys_addr(head_q, CntW'(1));
              count_d = count_q - 1'b1;
            end
          end
          CMD_DROP_BACK: begin
            if (!list_empty) begin
              count_d = count_q - 1'b1;
            end
          end
          default: begin
            status_d = ST_FAIL;
          end
        endcase
      end
      S_SEARCH: begin
        if (search_hit) begin
          idx_d  = pidx_q;
          pend_d = 1'b0;
        end else if (search_more) begin
          ra_en   = 1'b1;
          ra_addr = phys_addr(head_q, idx_q);
          pidx_d  = idx_q;
          pend_d  = 1'b1;
          idx_d   = idx_q + 1'b1;
        end else begin
          status_d = ST_FAIL;
          pend_d   = 1'b0;
        end
      end
      S_SHIFT: begin
        // Entries ahead of the match move one place towards the back.
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys_addr(head_q, pidx_q + 1'b1);
          ram_wdata = ra_data;
        end
        if (idx_q != '0) begin
          ra_en   = 1'b1;
          ra_addr = phys_addr(head_q, idx_q - 1'b1);
          pidx_d  = idx_q - 1'b1;
          pend_d  = 1'b1;
          idx_d   = idx_q - 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (shift_done) begin
          if (cmd_q == CMD_REMOVE) begin
            // The old front slot now holds a stale copy: step past it.
            head_d  = phys_addr(head_q, CntW'(1));
            count_d = count_q - 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_q;
            ram_wdata = handle_q;
          end
        end
      end
      S_ENDS: begin
        ra_en   = 1'b1;
        ra_addr = head_q;
        rb_en   = 1'b1;
        rb_addr = phys_addr(head_q, last_pos);
      end
      S_REPORT: begin
        if (out_free) begin
          out_d.status      = status_q;
          out_d.front_item  = list_empty ? '0 : ra_data;
          out_d.back_item   = list_empty ? '0 : rb_data;
          out_d.is_empty    = list_empty;
          out_d.entry_count = CountW'(count_q);
          out_valid_d       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    handle_q <= handle_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    pidx_q   <= pidx_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

// File: rtl/odq_ram.sv
// ----------------------------------------------------------------------------
// odq_ram: generic RAM with one write port and two registered read ports
// Read data is captured when the port's enable is high and held otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module odq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             ra_en_i,
  input  wire logic [AddrW-1:0] ra_addr_i,
  output logic      [Width-1:0] ra_data_o,
  input  wire logic             rb_en_i,
  input  wire logic [AddrW-1:0] rb_addr_i,
  output logic      [Width-1:0] rb_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ra_en_i) begin
      ra_data_o <= mem_q[ra_addr_i];
    end
    if (rb_en_i) begin
      rb_data_o <= mem_q[rb_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/odq_checker.sv
// ----------------------------------------------------------------------------
// odq_checker: port-level checks of the ordered deque
// Watches the result stream for consistency of the reported list state.
// ----------------------------------------------------------------------------
`default_nettype none

module odq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic [odq_pkg::InDataW-1:0]  s_axis_tdata,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic [odq_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready
);

  import odq_pkg::*;

  out_word_t res;
  in_word_t  cmd_word;
  logic      in_seen;

  assign res      = out_word_t'(m_axis_tdata);
  assign cmd_word = in_word_t'(s_axis_tdata);
  assign in_seen  = s_axis_tvalid && s_axis_tready && (cmd_word.command == cmd_word.command);

  // A stalled result stays on the bus unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.is_empty == (res.entry_count == '0))
    else $error("empty flag disagrees with entry count");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.is_empty |-> res.front_item == '0 && res.back_item == '0)
    else $error("empty list reports a front or back handle");

  a_nonzero_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.is_empty |-> res.front_item != '0 && res.back_item != '0)
    else $error("held list reports a zero handle at an end");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid || in_seen |-> int'(res.entry_count) <= Capacity || !m_axis_tvalid)
    else $error("entry count exceeds capacity");

endmodule

bind ordered_deque_with_remove odq_checker u_odq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
